FILE: rtl/dvrt_pkg.sv
// shared types and constants of the distance-vector route table
// used by dvrt_front, dvrt_engine, the top level and the checker
package dvrt_pkg;

    localparam logic [1:0] OP_ADVERT_ENTRY = 2'd0;
    localparam logic [1:0] OP_LOCAL_ROUTE  = 2'd1;
    localparam logic [1:0] OP_TICK         = 2'd2;
    localparam logic [1:0] OP_ADVERTISE    = 2'd3;

    localparam logic [2:0] KIND_DONE      = 3'd0;
    localparam logic [2:0] KIND_INSTALLED = 3'd1;
    localparam logic [2:0] KIND_IMPROVED  = 3'd2;
    localparam logic [2:0] KIND_REFRESHED = 3'd3;
    localparam logic [2:0] KIND_IGNORED   = 3'd4;
    localparam logic [2:0] KIND_FULL      = 3'd5;
    localparam logic [2:0] KIND_PURGED    = 3'd6;
    localparam logic [2:0] KIND_ADVERT    = 3'd7;

    localparam logic [1:0] REG_TTL_LIMIT    = 2'd0;
    localparam logic [1:0] REG_EXPIRE_TICKS = 2'd1;
    localparam logic [1:0] REG_SELF_ID      = 2'd2;
    localparam logic [1:0] REG_LOCAL_PORT   = 2'd3;

    localparam int RESULT_CAP = 64;
    localparam int CNT_W      = 7;

    typedef struct packed {
        logic [1:0]         op;
        logic [63:0]        route_key;
        logic [7:0]         adv_cost;
        logic [15:0]        neighbor_id;
        logic signed [8:0]  neighbor_port;
    } cmd_t;

    typedef struct packed {
        logic [7:0]         ttl_limit;
        logic [15:0]        expire_ticks;
        logic [15:0]        self_id;
        logic signed [8:0]  local_port;
    } cfg_t;

    typedef struct packed {
        logic [2:0]         kind;
        logic [63:0]        out_key;
        logic [7:0]         out_cost;
        logic signed [8:0]  out_port;
        logic [15:0]        out_next_hop;
        logic               last;
    } result_t;

    typedef struct packed {
        logic push;
        logic full;
        logic pop;
        logic avail;
    } q_ctrl_t;

endpackage

FILE: rtl/dvrt_front.sv
// front part: accepts input transactions into a two-entry command queue
// depends on dvrt_pkg
module dvrt_front
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  dvrt_pkg::cmd_t  in_cmd,
    input  logic            pop,
    output logic            avail,
    output dvrt_pkg::cmd_t  head
);

    dvrt_pkg::cmd_t slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    dvrt_pkg::q_ctrl_t ctl;

    always_comb
    begin
        ctl.full  = (count_reg == 2'd2);
        ctl.avail = (count_reg != 2'd0);
        ctl.push  = in_valid && !ctl.full;
        ctl.pop   = pop && ctl.avail;
        count_next = count_reg + {1'b0, ctl.push} - {1'b0, ctl.pop};
    end

    assign in_ready = !ctl.full;
    assign avail    = ctl.avail;
    assign head     = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (ctl.push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (ctl.pop)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.push)
            slot_reg[wr_ptr_reg] <= in_cmd;
    end

endmodule

FILE: rtl/dvrt_engine.sv
// back part: route memory, table walks, decisions and the result register
// depends on dvrt_pkg
module dvrt_engine
#(
    parameter int TABLE_DEPTH      = 64,
    parameter int NEIGHBOR_ID_BITS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  dvrt_pkg::cfg_t     cfg,
    input  logic               cmd_avail,
    input  dvrt_pkg::cmd_t     cmd_head,
    output logic               cmd_pop,
    output logic               res_valid,
    input  logic               res_ready,
    output dvrt_pkg::result_t  res
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int HB = (NEIGHBOR_ID_BITS < 16) ? NEIGHBOR_ID_BITS : 16;
    localparam logic [AW:0]   DEPTH_CNT = (AW+1)'(TABLE_DEPTH);
    localparam logic [AW-1:0] LAST_IDX  = AW'(TABLE_DEPTH - 1);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_DECIDE = 3'd2;
    localparam logic [2:0] ST_FLUSH  = 3'd3;

    // route memory
    logic [63:0]        mem_key   [TABLE_DEPTH];
    logic [7:0]         mem_cost  [TABLE_DEPTH];
    logic signed [8:0]  mem_port  [TABLE_DEPTH];
    logic [HB-1:0]      mem_hop   [TABLE_DEPTH];
    logic [31:0]        mem_stamp [TABLE_DEPTH];
    logic [63:0]        q_key_reg;
    logic [7:0]         q_cost_reg;
    logic signed [8:0]  q_port_reg;
    logic [HB-1:0]      q_hop_reg;
    logic [31:0]        q_stamp_reg;
    logic [TABLE_DEPTH-1:0] valid_reg;

    logic [2:0]         state_reg;
    dvrt_pkg::cmd_t     cmd_reg;
    logic [31:0]        time_reg;
    logic [AW:0]        icnt_reg;
    logic               p_vld_reg;
    logic [AW-1:0]      p_idx_reg;
    logic [dvrt_pkg::CNT_W-1:0] n_reg;
    logic               mf_reg;
    logic [AW-1:0]      midx_reg;
    logic [7:0]         mcost_reg;
    logic signed [8:0]  mport_reg;
    logic [HB-1:0]      mhop_reg;
    logic               ff_reg;
    logic [AW-1:0]      fidx_reg;
    logic               hold_vld_reg;
    dvrt_pkg::result_t  hold_reg;
    logic               out_vld_reg;
    dvrt_pkg::result_t  out_reg;

    logic               go;
    logic               issue;
    logic               pv;
    logic               is_lookup;
    logic [HB-1:0]      nb;
    logic [HB-1:0]      self_hop;
    logic [7:0]         new_cost;
    logic [31:0]        age;
    logic               hit;
    logic               emit;
    logic               cap_ok;
    dvrt_pkg::result_t  entry_res;
    dvrt_pkg::result_t  dec_res;
    logic               wr_all;
    logic               wr_stamp;
    logic [AW-1:0]      wr_idx;
    logic [7:0]         wr_cost;
    logic signed [8:0]  wr_port;
    logic [HB-1:0]      wr_hop;

    assign go        = !out_vld_reg || res_ready;
    assign issue     = (state_reg == ST_SCAN) && go && (icnt_reg < DEPTH_CNT);
    assign pv        = valid_reg[p_idx_reg];
    assign is_lookup = (cmd_reg.op == dvrt_pkg::OP_ADVERT_ENTRY)
                    || (cmd_reg.op == dvrt_pkg::OP_LOCAL_ROUTE);
    assign nb        = cmd_reg.neighbor_id[HB-1:0];
    assign self_hop  = cfg.self_id[HB-1:0];
    assign new_cost  = (cmd_reg.adv_cost == 8'hFF) ? 8'hFF : cmd_reg.adv_cost + 8'd1;
    assign age       = time_reg - q_stamp_reg;
    assign hit       = pv && (q_key_reg == cmd_reg.route_key);
    assign cap_ok    = (n_reg < dvrt_pkg::CNT_W'(dvrt_pkg::RESULT_CAP));
    assign cmd_pop   = (state_reg == ST_IDLE) && cmd_avail;
    assign res_valid = out_vld_reg;
    assign res       = out_reg;

    always_comb
    begin
        entry_res.kind         = (cmd_reg.op == dvrt_pkg::OP_TICK) ? dvrt_pkg::KIND_PURGED
                                                                  : dvrt_pkg::KIND_ADVERT;
        entry_res.out_key      = q_key_reg;
        entry_res.out_cost     = q_cost_reg;
        entry_res.out_port     = q_port_reg;
        entry_res.out_next_hop = 16'(q_hop_reg);
        entry_res.last         = 1'b0;
        emit = 1'b0;
        if (p_vld_reg && pv && cap_ok)
        begin
            if (cmd_reg.op == dvrt_pkg::OP_TICK)
                emit = (age >= {16'd0, cfg.expire_ticks});
            else if (cmd_reg.op == dvrt_pkg::OP_ADVERTISE)
                emit = (q_cost_reg < cfg.ttl_limit) && (q_hop_reg != nb);
        end
    end

    // decision after a lookup walk
    always_comb
    begin
        dec_res.out_key = cmd_reg.route_key;
        dec_res.last    = 1'b1;
        wr_all   = 1'b0;
        wr_stamp = 1'b0;
        wr_idx   = mf_reg ? midx_reg : fidx_reg;
        if (cmd_reg.op == dvrt_pkg::OP_LOCAL_ROUTE)
        begin
            wr_cost = 8'd0;
            wr_port = cfg.local_port;
            wr_hop  = self_hop;
        end
        else
        begin
            wr_cost = new_cost;
            wr_port = cmd_reg.neighbor_port;
            wr_hop  = nb;
        end
        dec_res.out_cost     = wr_cost;
        dec_res.out_port     = wr_port;
        dec_res.out_next_hop = 16'(wr_hop);
        if (!mf_reg && !ff_reg)
            dec_res.kind = dvrt_pkg::KIND_FULL;
        else if (!mf_reg)
        begin
            dec_res.kind = dvrt_pkg::KIND_INSTALLED;
            wr_all = 1'b1;
        end
        else if (cmd_reg.op == dvrt_pkg::OP_LOCAL_ROUTE)
        begin
            wr_all = 1'b1;
            dec_res.kind = (mcost_reg == 8'd0 && mport_reg == cfg.local_port
                            && mhop_reg == self_hop) ? dvrt_pkg::KIND_REFRESHED
                                                     : dvrt_pkg::KIND_IMPROVED;
        end
        else if (mcost_reg > new_cost)
        begin
            dec_res.kind = dvrt_pkg::KIND_IMPROVED;
            wr_all = 1'b1;
        end
        else
        begin
            dec_res.out_cost     = mcost_reg;
            dec_res.out_port     = mport_reg;
            dec_res.out_next_hop = 16'(mhop_reg);
            if (mcost_reg == new_cost && mhop_reg == nb)
            begin
                dec_res.kind = dvrt_pkg::KIND_REFRESHED;
                wr_stamp = 1'b1;
            end
            else
                dec_res.kind = dvrt_pkg::KIND_IGNORED;
        end
        if (!((state_reg == ST_DECIDE) && go))
        begin
            wr_all   = 1'b0;
            wr_stamp = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_all)
        begin
            mem_key[wr_idx]  <= cmd_reg.route_key;
            mem_cost[wr_idx] <= wr_cost;
            mem_port[wr_idx] <= wr_port;
            mem_hop[wr_idx]  <= wr_hop;
        end
        if (wr_all || wr_stamp)
            mem_stamp[wr_idx] <= time_reg;
        if (issue)
        begin
            q_key_reg   <= mem_key[icnt_reg[AW-1:0]];
            q_cost_reg  <= mem_cost[icnt_reg[AW-1:0]];
            q_port_reg  <= mem_port[icnt_reg[AW-1:0]];
            q_hop_reg   <= mem_hop[icnt_reg[AW-1:0]];
            q_stamp_reg <= mem_stamp[icnt_reg[AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
            cmd_reg <= cmd_head;
        if ((state_reg == ST_SCAN) && go && p_vld_reg)
        begin
            if (hit && !mf_reg)
            begin
                midx_reg  <= p_idx_reg;
                mcost_reg <= q_cost_reg;
                mport_reg <= q_port_reg;
                mhop_reg  <= q_hop_reg;
            end
            if (!pv && !ff_reg)
                fidx_reg <= p_idx_reg;
            if (emit)
                hold_reg <= entry_res;
        end
        if (go)
        begin
            if (state_reg == ST_DECIDE)
                out_reg <= dec_res;
            else if (state_reg == ST_FLUSH)
            begin
                if (hold_vld_reg)
                    out_reg <= {hold_reg.kind, hold_reg.out_key, hold_reg.out_cost,
                                hold_reg.out_port, hold_reg.out_next_hop, 1'b1};
                else
                    out_reg <= {dvrt_pkg::KIND_DONE, 97'd0, 1'b1};
            end
            else if ((state_reg == ST_SCAN) && emit && hold_vld_reg)
                out_reg <= hold_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            time_reg     <= 32'd0;
            valid_reg    <= '0;
            icnt_reg     <= '0;
            p_vld_reg    <= 1'b0;
            p_idx_reg    <= '0;
            n_reg        <= '0;
            mf_reg       <= 1'b0;
            ff_reg       <= 1'b0;
            hold_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            if (out_vld_reg && res_ready)
                out_vld_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (cmd_avail)
                    begin
                        if (cmd_head.op == dvrt_pkg::OP_TICK)
                            time_reg <= time_reg + 32'd1;
                        icnt_reg     <= '0;
                        p_vld_reg    <= 1'b0;
                        n_reg        <= '0;
                        mf_reg       <= 1'b0;
                        ff_reg       <= 1'b0;
                        hold_vld_reg <= 1'b0;
                        state_reg    <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    if (go)
                    begin
                        p_vld_reg <= issue;
                        p_idx_reg <= icnt_reg[AW-1:0];
                        if (issue)
                            icnt_reg <= icnt_reg + 1'b1;
                        if (p_vld_reg)
                        begin
                            if (hit)
                                mf_reg <= 1'b1;
                            if (!pv)
                                ff_reg <= 1'b1;
                            // purged entries go invalid even past the report cap
                            if (cmd_reg.op == dvrt_pkg::OP_TICK && pv
                                && age >= {16'd0, cfg.expire_ticks})
                                valid_reg[p_idx_reg] <= 1'b0;
                            if (emit)
                            begin
                                n_reg        <= n_reg + 1'b1;
                                hold_vld_reg <= 1'b1;
                                if (hold_vld_reg)
                                    out_vld_reg <= 1'b1;
                            end
                            if (p_idx_reg == LAST_IDX)
                                state_reg <= is_lookup ? ST_DECIDE : ST_FLUSH;
                        end
                    end
                end
                ST_DECIDE:
                begin
                    if (go)
                    begin
                        if (wr_all)
                            valid_reg[wr_idx] <= 1'b1;
                        out_vld_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                ST_FLUSH:
                begin
                    if (go)
                    begin
                        out_vld_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

FILE: rtl/distance_vector_route_table.sv
// top level of the distance-vector content route table
// depends on dvrt_pkg, dvrt_front and dvrt_engine
//
// Every operation walks the whole table, one entry per clock through a
// registered memory read when results are taken at once; the walk is the
// limit, and a stalled result output freezes it. An advertisement entry
// or a local route first looks up the key and the first free slot, then
// decides, updates the slot unless the table is full or the route is
// ignored, and returns one result. A tick advances time by one and purges
// aged routes with one result per purge (the first 64 reported). An
// advertise query returns every route under ttl_limit not learned from the
// asking neighbor, at most 64. An operation with nothing to report returns
// one done result. The last result of an item carries tlast. A two-entry
// command queue sits in front of the engine so new transactions are taken
// while a walk is under way. Configuration writes are accepted every cycle
// and belong to idle periods only.
module distance_vector_route_table
#(
    parameter int TABLE_DEPTH      = 64,
    parameter int NEIGHBOR_ID_BITS = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    // input stream
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [103:0] s_axis_tdata,   // route_key, adv_cost, neighbor_id, neighbor_port
    input  logic [1:0]   s_axis_tuser,   // op
    // result stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [103:0] m_axis_tdata,   // out_key, out_cost, out_port, out_next_hop
    output logic [2:0]   m_axis_tuser,   // kind
    output logic         m_axis_tlast,
    // register writes
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_data
);

    dvrt_pkg::cfg_t    cfg_reg;
    dvrt_pkg::cmd_t    in_cmd;
    dvrt_pkg::cmd_t    head;
    dvrt_pkg::result_t res;
    logic              avail;
    logic              pop;

    assign cfg_ready = 1'b1;

    // register file, reset to the documented defaults
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ttl_limit    <= 8'd255;
            cfg_reg.expire_ticks <= 16'd30;
            cfg_reg.self_id      <= 16'd0;
            cfg_reg.local_port   <= 9'sd254;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                dvrt_pkg::REG_TTL_LIMIT:    cfg_reg.ttl_limit    <= cfg_data[7:0];
                dvrt_pkg::REG_EXPIRE_TICKS: cfg_reg.expire_ticks <= cfg_data;
                dvrt_pkg::REG_SELF_ID:      cfg_reg.self_id      <= cfg_data;
                dvrt_pkg::REG_LOCAL_PORT:   cfg_reg.local_port   <= cfg_data[8:0];
                default:                    cfg_reg.ttl_limit    <= cfg_reg.ttl_limit;
            endcase
        end
    end

    // unpack the input transaction
    assign in_cmd.op            = s_axis_tuser;
    assign in_cmd.route_key     = s_axis_tdata[63:0];
    assign in_cmd.adv_cost      = s_axis_tdata[71:64];
    assign in_cmd.neighbor_id   = s_axis_tdata[87:72];
    assign in_cmd.neighbor_port = s_axis_tdata[96:88];

    dvrt_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_cmd   (in_cmd),
        .pop      (pop),
        .avail    (avail),
        .head     (head)
    );

    dvrt_engine
    #(
        .TABLE_DEPTH      (TABLE_DEPTH),
        .NEIGHBOR_ID_BITS (NEIGHBOR_ID_BITS)
    )
    u_engine
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd_avail (avail),
        .cmd_head  (head),
        .cmd_pop   (pop),
        .res_valid (m_axis_tvalid),
        .res_ready (m_axis_tready),
        .res       (res)
    );

    // pack the result transaction
    assign m_axis_tdata = {7'd0, res.out_next_hop, res.out_port, res.out_cost, res.out_key};
    assign m_axis_tuser = res.kind;
    assign m_axis_tlast = res.last;

endmodule

FILE: rtl/dvrt_checker.sv
// port-level checks of the route table and their binding to the top level
// depends on dvrt_pkg and distance_vector_route_table
module dvrt_checker
(
    input logic         clk,
    input logic         rst_n,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [103:0] m_axis_tdata,
    input logic [2:0]   m_axis_tuser,
    input logic         m_axis_tlast,
    input logic         cfg_ready
);

    // a held result transaction keeps its payload
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    // single-result kinds always close their item
    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser != dvrt_pkg::KIND_PURGED
        && m_axis_tuser != dvrt_pkg::KIND_ADVERT |-> m_axis_tlast)
        else $error("single result without tlast");

    // a done result reports nothing
    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == dvrt_pkg::KIND_DONE |-> m_axis_tdata == '0)
        else $error("done result with payload");

    // register writes never wait
    a_cfg: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
        else $error("register port stalled");

endmodule

bind distance_vector_route_table dvrt_checker u_dvrt_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_ready     (cfg_ready)
);
